// File: hdl/lbs_pkg.sv
package lbs_pkg;
  localparam int MAX_BONES_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEMS_PER_BONE = 12;
  localparam int WEIGHT_FRAC = 15;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SKIN = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch the vertex word
    logic rd;      // issue a palette read for current lane and element
    logic mac_blend;
    logic clr_blend;
    logic mac_pos;
    logic clr_pos;
    logic store_blend;
    logic store_out;
    logic load_out;  // move the finished rows into the output register
  } lbs_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] mx;
    logic signed [63:0] mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    if (v > mx) return 32'sh7fffffff;
    if (v < mn) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// File: hdl/lbs_datapath.sv
module lbs_datapath #(
  parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
  parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               load_we,
  input  logic [11:0]        load_address,
  input  logic signed [31:0] load_value,
  input  lbs_pkg::lbs_cmd_t  cmd,
  input  logic [1:0]         lane,
  input  logic [3:0]         elem,
  input  logic [1:0]         col,
  input  logic [63:0]        infl_idx,
  input  logic [63:0]        infl_wgt,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z
);
  localparam int DEPTH = MAX_BONES * lbs_pkg::ELEMS_PER_BONE;
  localparam int AW = $clog2(DEPTH);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic [15:0] w_d_r;
  logic [63:0] idx_r, wgt_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] blend_r [12];
  logic signed [63:0] acc_r;
  logic signed [31:0] row_res_r [3];
  logic signed [31:0] out_r [3];
  logic [15:0] cur_idx;
  logic [AW+4:0] raddr;
  logic signed [63:0] prod;
  logic signed [63:0] pprod;
  logic [1:0] row;
  logic [3:0] melem;

  assign cur_idx = idx_r[16*lane +: 16];
  assign raddr = (AW+5)'(cur_idx) * (AW+5)'(lbs_pkg::ELEMS_PER_BONE) + (AW+5)'(elem);
  assign prod = $signed({1'b0, w_d_r}) * 64'(rdata_r);
  // Position pass: element row*4+col, with col 3 the translation.
  assign row = elem[1:0];
  assign melem = {row, col};
  assign pprod = 64'(blend_r[melem]) * 64'(pos_r[col]);

  always_ff @(posedge clk) begin
    if (load_we && ({20'd0, load_address} < 32'(DEPTH))) mem[AW'(load_address)] <= load_value;
    if (cmd.rd) begin
      rdata_r <= mem[raddr[AW-1:0]];
      w_d_r   <= wgt_r[16*lane +: 16];
    end
    if (cmd.start) begin
      idx_r <= infl_idx;
      wgt_r <= infl_wgt;
      pos_r[0] <= pos_x;
      pos_r[1] <= pos_y;
      pos_r[2] <= pos_z;
    end
    if (cmd.clr_blend || cmd.clr_pos) acc_r <= '0;
    else if (cmd.mac_blend) acc_r <= acc_r + (prod >>> lbs_pkg::WEIGHT_FRAC);
    else if (cmd.mac_pos) begin
      if (col == 2'd3) acc_r <= acc_r + 64'(blend_r[melem]);
      else acc_r <= acc_r + (pprod >>> FRAC_BITS);
    end
    if (cmd.store_blend) blend_r[elem] <= lbs_pkg::sat32(acc_r);
    if (cmd.store_out) row_res_r[row] <= lbs_pkg::sat32(acc_r);
    if (cmd.load_out) begin
      out_r[0] <= row_res_r[0];
      out_r[1] <= row_res_r[1];
      out_r[2] <= row_res_r[2];
    end
  end

  assign res_x = out_r[0];
  assign res_y = out_r[1];
  assign res_z = out_r[2];
endmodule

// File: hdl/lbs_ctrl.sv
module lbs_ctrl #(
  parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [63:0]       in_infl_idx,
  input  logic              in_last_vertex,
  input  logic [8:0]        bone_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_written,
  output logic              out_index_fault,
  output logic              load_we,
  output lbs_pkg::lbs_cmd_t cmd,
  output logic [1:0]        lane,
  output logic [3:0]        elem,
  output logic [1:0]        col
);
  typedef enum logic [2:0] {S_IDLE, S_BLEND, S_BSTORE, S_POS, S_PSTORE, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic [1:0] lane_r, lane_nxt, col_r, col_nxt;
  logic [3:0] elem_r, elem_nxt;
  logic aborted_r, aborted_nxt, last_r, last_nxt;
  logic ov_r, ov_nxt, wr_r, wr_nxt, flt_r, flt_nxt;
  logic rdv_r, rdv_nxt;
  logic acc, fault;
  logic [12:0] limit;

  assign limit = (13'(bone_count) > 13'(MAX_BONES)) ? 13'(MAX_BONES) : 13'(bone_count);
  always_comb begin
    fault = 1'b0;
    for (int k = 0; k < 4; k++)
      if (17'(in_infl_idx[16*k +: 16]) >= 17'(limit)) fault = 1'b1;
  end

  // A load moves at once. A vertex that answers at once needs the output
  // slot free; a vertex to be skinned may start while a result still waits.
  assign in_stall = (state_r != S_IDLE) ||
                    (in_action == lbs_pkg::ACT_SKIN && ov_r && (aborted_r || fault));
  assign acc = in_valid && !in_stall;
  assign load_we = acc && in_action == lbs_pkg::ACT_LOAD;

  always_comb begin
    state_nxt = state_r; lane_nxt = lane_r; elem_nxt = elem_r; col_nxt = col_r;
    aborted_nxt = aborted_r; last_nxt = last_r; ov_nxt = ov_r; wr_nxt = wr_r;
    flt_nxt = flt_r; rdv_nxt = 1'b0;
    cmd = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc && in_action == lbs_pkg::ACT_SKIN) begin
          if (aborted_r || fault) begin
            ov_nxt = 1'b1; wr_nxt = 1'b0; flt_nxt = !aborted_r;
            aborted_nxt = in_last_vertex ? 1'b0 : 1'b1;
          end else begin
            cmd.start = 1'b1; last_nxt = in_last_vertex;
            lane_nxt = '0; elem_nxt = '0; cmd.clr_blend = 1'b1;
            state_nxt = S_BLEND;
          end
        end
      end
      S_BLEND: begin
        // Accumulation runs in the cycle after each read issue. The lane wraps
        // to zero after the fourth read, so lane zero with data pending is
        // the last accumulate.
        if (rdv_r) cmd.mac_blend = 1'b1;
        if (rdv_r && lane_r == 2'd0) state_nxt = S_BSTORE;
        else begin
          cmd.rd = 1'b1; rdv_nxt = 1'b1; lane_nxt = lane_r + 2'd1;
        end
      end
      S_BSTORE: begin
        cmd.store_blend = 1'b1;
        state_nxt = S_BLEND; lane_nxt = '0;
        if (elem_r == 4'd11) begin
          elem_nxt = '0; col_nxt = '0; state_nxt = S_POS;
        end else elem_nxt = elem_r + 4'd1;
      end
      S_POS: begin
        cmd.mac_pos = 1'b1;
        if (col_r == 2'd3) state_nxt = S_PSTORE;
        else col_nxt = col_r + 2'd1;
      end
      S_PSTORE: begin
        cmd.store_out = 1'b1; col_nxt = '0;
        if (elem_r == 4'd2) state_nxt = S_OUT;
        else begin elem_nxt = elem_r + 4'd1; state_nxt = S_POS; end
      end
      S_OUT: begin
        // Wait here while the previous result is still held.
        if (!ov_r || !out_stall) begin
          cmd.load_out = 1'b1;
          ov_nxt = 1'b1; wr_nxt = 1'b1; flt_nxt = 1'b0;
          if (last_r) aborted_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_BSTORE || state_r == S_PSTORE) cmd.clr_blend = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; aborted_r <= 1'b0; ov_r <= 1'b0; rdv_r <= 1'b0;
      lane_r <= '0; elem_r <= '0; col_r <= '0; last_r <= 1'b0;
      wr_r <= 1'b0; flt_r <= 1'b0;
    end else begin
      state_r <= state_nxt; aborted_r <= aborted_nxt; ov_r <= ov_nxt;
      rdv_r <= rdv_nxt; lane_r <= lane_nxt; elem_r <= elem_nxt; col_r <= col_nxt;
      last_r <= last_nxt; wr_r <= wr_nxt; flt_r <= flt_nxt;
    end
  end

  assign lane = lane_r;
  assign elem = elem_r;
  assign col = col_r;
  assign out_valid = ov_r;
  assign out_written = wr_r;
  assign out_index_fault = flt_r;
endmodule

// File: hdl/linear_blend_skinning_top.sv
// Four-bone linear blend skinning. Palette words (action 0) are written as
// they are taken, and are taken whenever no vertex is being computed. A vertex
// word (action 1) is handled by one shared accumulator fed by a single
// palette read port: each of the 12 blended elements is built from four lane
// reads, each accumulated after its read, and a store, and each of the three
// output rows from four terms and a store. No new word is taken until the
// result is loaded. The result sits in an output register, so a vertex may
// start while the previous result still waits; it then holds in its last
// step until that result leaves. A faulting or skipped vertex answers on the
// next cycle but is only taken while the output register is empty. Palette
// contents are undefined until written; bone_count is at address 0 of the
// configuration port.
module linear_blend_skinning_top #(
  parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF,
  parameter int FRAC_BITS = lbs_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [11:0]        in_load_address,
  input  logic signed [31:0] in_load_value,
  input  logic [63:0]        in_infl_idx,
  input  logic [63:0]        in_infl_wgt,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_skinned_x,
  output logic signed [31:0] out_skinned_y,
  output logic signed [31:0] out_skinned_z,
  output logic               out_written,
  output logic               out_index_fault,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  logic [8:0] bone_count_r;
  lbs_pkg::lbs_cmd_t cmd;
  logic load_we;
  logic [1:0] lane, col;
  logic [3:0] elem;
  logic signed [31:0] rx, ry, rz;

  // Only one register, written at address zero; reads return it at any address.
  assign pready = 1'b1;
  assign prdata = {23'd0, bone_count_r};
  always_ff @(posedge clk) begin
    if (!rst_n) bone_count_r <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) bone_count_r <= pwdata[8:0];
  end

  lbs_ctrl #(.MAX_BONES(MAX_BONES)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_infl_idx,
    .in_last_vertex, .bone_count(bone_count_r), .out_valid, .out_stall,
    .out_written, .out_index_fault, .load_we, .cmd, .lane, .elem, .col
  );

  lbs_datapath #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .load_we, .load_address(in_load_address), .load_value(in_load_value),
    .cmd, .lane, .elem, .col, .infl_idx(in_infl_idx),
    .infl_wgt(in_infl_wgt), .pos_x(in_pos_x), .pos_y(in_pos_y),
    .pos_z(in_pos_z), .res_x(rx), .res_y(ry), .res_z(rz)
  );

  // A skipped vertex reports zero coordinates.
  assign out_skinned_x = out_written ? rx : '0;
  assign out_skinned_y = out_written ? ry : '0;
  assign out_skinned_z = out_written ? rz : '0;
endmodule

// File: hdl/lbs_checker.sv
module lbs_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_written,
  input logic out_index_fault,
  input logic [31:0] out_skinned_x
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_written && out_index_fault)) else $error("written and fault");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_written |-> out_skinned_x == 32'd0) else $error("skip not zero");
endmodule

bind linear_blend_skinning_top lbs_checker u_chk (.*);
